>>> rtl/core/dprc_pkg.sv
// shared types and constants for the debounced pulse relay controller
`default_nettype none

package dprc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned RpmW  = 20;
  localparam int unsigned EvW   = 3;
  localparam int unsigned ReqW  = 2;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 5;
  localparam int unsigned IdxW  = 3;

  typedef logic [TimeW-1:0] time_ms_t;
  typedef logic [RpmW-1:0]  rpm_t;
  typedef logic [EvW-1:0]   ev_t;
  typedef logic [ReqW-1:0]  req_t;
  typedef logic [IdxW-1:0]  reg_idx_t;

  localparam req_t REQ_PERIODIC  = 2'd0;
  localparam req_t REQ_FORCE_ON  = 2'd1;
  localparam req_t REQ_FORCE_OFF = 2'd2;
  localparam req_t REQ_RELAY_OFF = 2'd3;

  localparam ev_t EV_NONE      = 3'd0;
  localparam ev_t EV_TIMEOUT   = 3'd1;
  localparam ev_t EV_ACTIVATED = 3'd2;
  localparam ev_t EV_FORCE_ON  = 3'd3;
  localparam ev_t EV_FORCE_OFF = 3'd4;

  localparam reg_idx_t REG_STOP_TIMEOUT = 3'd0;
  localparam reg_idx_t REG_THRESHOLD    = 3'd1;
  localparam reg_idx_t REG_PULSE_ON     = 3'd2;
  localparam reg_idx_t REG_INTERVAL     = 3'd3;
  localparam reg_idx_t REG_DEBOUNCE     = 3'd4;

  localparam time_ms_t STOP_TIMEOUT_RST = 32'd2000;
  localparam rpm_t     THRESHOLD_RST    = 20'd1000;
  localparam time_ms_t PULSE_ON_RST     = 32'd500;
  localparam time_ms_t INTERVAL_RST     = 32'd2000;
  localparam time_ms_t DEBOUNCE_RST     = 32'd120;

endpackage

`default_nettype wire

>>> rtl/core/debounced_pulse_relay_controller.sv
// top level of the debounced pulse relay controller
`default_nettype none

// Takes one request per clock cycle while in_stall is low and returns exactly one result
// per request, in order. A request waits in the input register; the edge that applies it to
// the controller state also loads its result into the output register, and it comes only
// when the output register is empty or not stalled. The output register holds a
// result that waits; the input side stalls only when a valid result is stalled and the input
// register is full. The state update is one pass of
// wrapping 32-bit subtract and compare logic between those two registers, and that pass sets
// the rate of one request per cycle while not stalled. Registers sit at byte addresses 0, 4,
// 8, 12 and 16, in the order stop timeout, speed threshold, pulse on time, pulse interval and
// debounce time. A write must come only while no request is in flight.
module debounced_pulse_relay_controller (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  dprc_pkg::req_t    in_req_type,
  input  wire  dprc_pkg::time_ms_t in_now_ms,
  input  wire  dprc_pkg::rpm_t    in_rpm_tenths,
  input  wire  dprc_pkg::time_ms_t in_last_move_ms,
  input  wire                     in_move_seen,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic                    out_relay_on,
  output logic                    out_active,
  output dprc_pkg::ev_t           out_event_res,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire  [dprc_pkg::AddrW-1:0] paddr,
  input  wire  [dprc_pkg::DataW-1:0] pwdata,
  output logic [dprc_pkg::DataW-1:0] prdata,
  output logic                    pready
);
  import dprc_pkg::*;

  // configuration
  time_ms_t stop_timeout_r;
  rpm_t     threshold_r;
  time_ms_t pulse_on_r;
  time_ms_t interval_r;
  time_ms_t debounce_r;

  // input register
  logic     s1_valid_r;
  req_t     s1_req_r;
  time_ms_t s1_now_r;
  rpm_t     s1_rpm_r;
  time_ms_t s1_last_move_r;
  logic     s1_seen_r;

  // controller state
  logic     active_r, active_nxt;
  logic     relay_r, relay_nxt;
  logic     in_pulse_r, in_pulse_nxt;
  time_ms_t phase_start_r, phase_start_nxt;
  logic     deb_run_r, deb_run_nxt;
  time_ms_t deb_start_r, deb_start_nxt;
  ev_t      ev_nxt;

  // output register
  logic     out_valid_r;
  logic     out_relay_r;
  logic     out_active_r;
  ev_t      out_event_r;

  logic     advance;
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  time_ms_t since_move;
  time_ms_t since_phase;
  time_ms_t since_deb;
  time_ms_t deb_start_eff;
  time_ms_t off_time;
  logic     stopped;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_timeout_r <= STOP_TIMEOUT_RST;
      threshold_r    <= THRESHOLD_RST;
      pulse_on_r     <= PULSE_ON_RST;
      interval_r     <= INTERVAL_RST;
      debounce_r     <= DEBOUNCE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STOP_TIMEOUT: stop_timeout_r <= pwdata;
        REG_THRESHOLD:    threshold_r    <= pwdata[RpmW-1:0];
        REG_PULSE_ON:     pulse_on_r     <= pwdata;
        REG_INTERVAL:     interval_r     <= pwdata;
        REG_DEBOUNCE:     debounce_r     <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STOP_TIMEOUT: prdata = stop_timeout_r;
      REG_THRESHOLD:    prdata = {{(DataW-RpmW){1'b0}}, threshold_r};
      REG_PULSE_ON:     prdata = pulse_on_r;
      REG_INTERVAL:     prdata = interval_r;
      REG_DEBOUNCE:     prdata = debounce_r;
      default:          prdata = '0;
    endcase
  end

  // flow control
  assign advance  = s1_valid_r & ~(out_valid_r & out_stall);
  assign in_stall = s1_valid_r & out_valid_r & out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r       <= in_req_type;
      s1_now_r       <= in_now_ms;
      s1_rpm_r       <= in_rpm_tenths;
      s1_last_move_r <= in_last_move_ms;
      s1_seen_r      <= in_move_seen;
    end
  end

  // state update for the item in the input register
  always_comb begin
    since_move    = s1_now_r - s1_last_move_r;
    since_phase   = s1_now_r - phase_start_r;
    deb_start_eff = deb_run_r ? deb_start_r : s1_now_r;
    since_deb     = s1_now_r - deb_start_eff;
    off_time      = interval_r - pulse_on_r;
    stopped       = ~s1_seen_r | (since_move >= stop_timeout_r);

    active_nxt      = active_r;
    relay_nxt       = relay_r;
    in_pulse_nxt    = in_pulse_r;
    phase_start_nxt = phase_start_r;
    deb_run_nxt     = deb_run_r;
    deb_start_nxt   = deb_start_r;
    ev_nxt          = EV_NONE;

    case (s1_req_r)
      REQ_PERIODIC: begin
        if (stopped) begin
          if (active_r) begin
            active_nxt = 1'b0;
            relay_nxt  = 1'b0;
            ev_nxt     = EV_TIMEOUT;
          end
          deb_run_nxt = 1'b0;
        end else if (!active_r) begin
          if (s1_rpm_r >= threshold_r) begin
            deb_run_nxt   = 1'b1;
            deb_start_nxt = deb_start_eff;
            if (since_deb >= debounce_r) begin
              active_nxt  = 1'b1;
              deb_run_nxt = 1'b0;
              ev_nxt      = EV_ACTIVATED;
              if (!in_pulse_r) begin
                in_pulse_nxt    = 1'b1;
                phase_start_nxt = s1_now_r;
                relay_nxt       = 1'b1;
              end
            end
          end else begin
            deb_run_nxt = 1'b0;
          end
        end else if (in_pulse_r) begin
          if (since_phase >= pulse_on_r) begin
            relay_nxt       = 1'b0;
            phase_start_nxt = s1_now_r;
            in_pulse_nxt    = 1'b0;
          end
        end else if (since_phase >= off_time) begin
          phase_start_nxt = s1_now_r;
          in_pulse_nxt    = 1'b1;
          relay_nxt       = 1'b1;
        end
      end
      REQ_FORCE_ON: begin
        active_nxt      = 1'b1;
        in_pulse_nxt    = 1'b1;
        phase_start_nxt = s1_now_r;
        deb_run_nxt     = 1'b0;
        relay_nxt       = 1'b1;
        ev_nxt          = EV_FORCE_ON;
      end
      REQ_FORCE_OFF: begin
        active_nxt  = 1'b0;
        deb_run_nxt = 1'b0;
        relay_nxt   = 1'b0;
        ev_nxt      = EV_FORCE_OFF;
      end
      default: begin
        relay_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      relay_r       <= 1'b0;
      in_pulse_r    <= 1'b0;
      phase_start_r <= '0;
      deb_run_r     <= 1'b0;
      deb_start_r   <= '0;
    end else if (advance) begin
      active_r      <= active_nxt;
      relay_r       <= relay_nxt;
      in_pulse_r    <= in_pulse_nxt;
      phase_start_r <= phase_start_nxt;
      deb_run_r     <= deb_run_nxt;
      deb_start_r   <= deb_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_relay_r  <= relay_nxt;
      out_active_r <= active_nxt;
      out_event_r  <= ev_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_relay_on  = out_relay_r;
  assign out_active    = out_active_r;
  assign out_event_res = out_event_r;

`ifndef SYNTHESIS
  a_relay_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    relay_r |-> active_r)
    else $error("relay energized while inactive");

  a_timeout_drops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_TIMEOUT |-> !out_active && !out_relay_on)
    else $error("timeout result still active");

  a_force_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_FORCE_ON |-> out_active && out_relay_on)
    else $error("force on result not energized");

  a_force_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_FORCE_OFF |-> !out_active && !out_relay_on)
    else $error("force off result still on");

  a_activated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_ACTIVATED |-> out_active)
    else $error("activation result not active");

  a_state_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid && out_active == active_r && out_relay_on == relay_r)
    else $error("result disagrees with state");
`endif

endmodule

`default_nettype wire
